/* hdl/lpr_pkg.sv */
// ---------------------------------------------------------------------------
// lpr_pkg
// Shared types and constants for the line pixel rasterizer.
// ---------------------------------------------------------------------------
package lpr_pkg;

    // request codes
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_NEXT  = 1'b1;

    // quotient never exceeds the 9-bit rise, so nine restoring steps suffice
    localparam int DIV_STEPS = 9;
    typedef logic [3:0] t_step_cnt;

    typedef struct packed {
        logic       req_type;
        logic [9:0] x_start;
        logic [8:0] y_start;
        logic [9:0] x_end;
        logic [8:0] y_end;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_req;

    typedef struct packed {
        logic [9:0]  pixel_x;
        logic [8:0]  pixel_y;
        logic [18:0] pixel_index;
        logic [7:0]  red_out;
        logic [7:0]  green_out;
        logic [7:0]  blue_out;
        logic        last_pixel;
    } t_pix;

    // controller -> datapath
    typedef struct packed {
        logic load;      // request word accepted
        logic mul;       // form rise*run, seed divider
        logic div_step;  // one restoring step
        logic fin;       // apply quotient to first row
        logic emit;      // load output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic emit_req;  // accepted word produces a pixel
        logic out_free;  // output register can take a word
    } t_dp_sts;

endpackage

/* hdl/lpr_req_if.sv */
// ---------------------------------------------------------------------------
// lpr_req_if
// Valid/ready channel carrying request words.
// ---------------------------------------------------------------------------
interface lpr_req_if;
    import lpr_pkg::*;

    logic valid;
    logic ready;
    t_req payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* hdl/lpr_pix_if.sv */
// ---------------------------------------------------------------------------
// lpr_pix_if
// Valid/ready channel carrying pixel words.
// ---------------------------------------------------------------------------
interface lpr_pix_if;
    import lpr_pkg::*;

    logic valid;
    logic ready;
    t_pix payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* hdl/lpr_ctrl.sv */
// ---------------------------------------------------------------------------
// lpr_ctrl
// Sequencer: accept, multiply, divide steps, finish, output.
// ---------------------------------------------------------------------------
module lpr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  lpr_pkg::t_dp_sts  i_sts,
    output lpr_pkg::t_dp_cmd  o_cmd
);
    import lpr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_FIN,
        S_OUT
    } t_state;

    localparam t_step_cnt DivLast = t_step_cnt'(DIV_STEPS - 1);

    t_state    r_state, n_state;
    t_step_cnt r_cnt, n_cnt;
    logic      accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_sts.emit_req) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_DIV;
                n_cnt   = '0;
            end
            S_DIV: begin
                n_cnt = r_cnt + t_step_cnt'(1);
                if (r_cnt == DivLast) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = accept;
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.fin      = (r_state == S_FIN);
        o_cmd.emit     = (r_state == S_OUT) && i_sts.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

/* hdl/lpr_dp.sv */
// ---------------------------------------------------------------------------
// lpr_dp
// Line state, rise*run multiplier, restoring divider and output register.
// ---------------------------------------------------------------------------
module lpr_dp #(
    parameter int FRAME_WIDTH = 640
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lpr_pkg::t_dp_cmd  i_cmd,
    output lpr_pkg::t_dp_sts  o_sts,
    input  lpr_pkg::t_req     i_req,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output lpr_pkg::t_pix     o_pix
);
    import lpr_pkg::*;

    localparam logic [18:0] FrameWidthMod = 19'(FRAME_WIDTH);

    // latched line
    logic [9:0] r_first_col, r_final_col, r_next_col, r_x, r_span;
    logic [8:0] r_first_row, r_final_row, r_y;
    logic [7:0] r_red, r_green, r_blue;
    logic       r_line_active, r_desc;

    // divider
    logic [9:0] r_rem;
    logic [8:0] r_quo;

    logic        r_out_valid;
    t_pix        r_pix;

    logic [9:0]  span, run;
    logic [8:0]  rise, quot;
    logic [18:0] prod;
    logic [10:0] trial;
    logic [11:0] diff;
    logic [18:0] index;
    logic        is_last;

    assign span  = r_final_col - r_first_col;
    assign run   = r_x - r_first_col;
    assign rise  = (r_final_row < r_first_row) ? (r_first_row - r_final_row)
                                               : (r_final_row - r_first_row);
    assign prod  = 19'(rise) * 19'(run);

    // partial remainder stays below the span, so 11 bits cover the shift-in
    assign trial = {r_rem, r_quo[8]};
    assign diff  = {1'b0, trial} - {2'b00, r_span};

    assign quot    = (r_span == '0) ? '0 : r_quo;
    assign index   = 19'(r_y) * FrameWidthMod + 19'(r_x);
    assign is_last = (r_x == r_final_col);

    always_comb begin
        o_sts = '0;
        if (i_req.req_type == REQ_START) begin
            o_sts.emit_req = (i_req.x_end >= i_req.x_start);
        end else begin
            o_sts.emit_req = r_line_active;
        end
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if (i_req.req_type == REQ_START) begin
                r_first_col <= i_req.x_start;
                r_first_row <= i_req.y_start;
                r_final_col <= i_req.x_end;
                r_final_row <= i_req.y_end;
                r_red       <= i_req.red_in;
                r_green     <= i_req.green_in;
                r_blue      <= i_req.blue_in;
                r_x         <= i_req.x_start;
            end else begin
                r_x <= r_next_col;
            end
        end
        if (i_cmd.mul) begin
            r_span <= span;
            r_desc <= (r_final_row < r_first_row);
            r_rem  <= prod[18:9];
            r_quo  <= prod[8:0];
        end
        if (i_cmd.div_step) begin
            if (!diff[11]) begin
                r_rem <= diff[9:0];
                r_quo <= {r_quo[7:0], 1'b1};
            end else begin
                r_rem <= trial[9:0];
                r_quo <= {r_quo[7:0], 1'b0};
            end
        end
        if (i_cmd.fin) begin
            r_y <= r_desc ? (r_first_row - quot) : (r_first_row + quot);
        end
        if (i_cmd.emit) begin
            r_pix.pixel_x     <= r_x;
            r_pix.pixel_y     <= r_y;
            r_pix.pixel_index <= index;
            r_pix.red_out     <= r_red;
            r_pix.green_out   <= r_green;
            r_pix.blue_out    <= r_blue;
            r_pix.last_pixel  <= is_last;
            r_next_col        <= r_x + 10'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_active <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cmd.load && (i_req.req_type == REQ_START)) begin
                r_line_active <= 1'b0;
            end else if (i_cmd.emit) begin
                r_line_active <= !is_last;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pix       = r_pix;

endmodule

/* hdl/line_pixel_rasterizer.sv */
// ---------------------------------------------------------------------------
// line_pixel_rasterizer
// X-major line rasterizer: at most one pixel word per start or next request.
//
//   channel   dir   word    handshake
//   i_req     in    t_req   valid/ready
//   o_pix     out   t_pix   valid/ready
//
// A request that produces a pixel goes from accept to the output register
// through accept, multiply, 9 restoring divider steps, row add, output load.
// A request that produces nothing is done in its accept cycle.
// One request is in flight at a time; i_req.ready is high only when idle.
// A held output stalls the sequencer in its last step only.
// Reset is synchronous, active low, and leaves no line active.
// ---------------------------------------------------------------------------
module line_pixel_rasterizer #(
    parameter int FRAME_WIDTH = 640
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lpr_req_if.sink    i_req,
    lpr_pix_if.source  o_pix
);
    import lpr_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    lpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lpr_dp #(
        .FRAME_WIDTH (FRAME_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req       (i_req.payload),
        .i_out_ready (o_pix.ready),
        .o_out_valid (o_pix.valid),
        .o_pix       (o_pix.payload)
    );

endmodule

/* hdl/lpr_checker.sv */
// ---------------------------------------------------------------------------
// lpr_checker
// Port-level checks on the rasterizer, bound to the top level.
// ---------------------------------------------------------------------------
module lpr_checker #(
    parameter int FRAME_WIDTH = 640
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_ready,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input lpr_pkg::t_pix i_pix
);
    import lpr_pkg::*;

    localparam logic [18:0] FrameWidthMod = 19'(FRAME_WIDTH);

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_pix))
        else $error("pixel word changed while stalled");

    // index agrees with the coordinates it carries
    a_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            i_pix.pixel_index == 19'(19'(i_pix.pixel_y) * FrameWidthMod
                                     + 19'(i_pix.pixel_x)))
        else $error("pixel index mismatch");

    // a new word is only produced while the request side is busy
    a_busy_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("pixel word appeared while idle");

endmodule

bind line_pixel_rasterizer lpr_checker #(
    .FRAME_WIDTH (FRAME_WIDTH)
) u_lpr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_pix       (o_pix.payload)
);

/* bench/line_pixel_rasterizer_test.sv */
// ---------------------------------------------------------------------------
// line_pixel_rasterizer_test
// Self-checking bench for the line pixel rasterizer. A queue of request
// words feeds a driver at the falling edge; accepted words go through a
// behavioral line tracer that predicts each pixel word. A monitor at the
// rising edge compares every pixel word field by field with the oldest
// prediction. Directed lines cover the corner cases, then random line
// sequences with random stalls on both channels.
// ---------------------------------------------------------------------------
module line_pixel_rasterizer_test;
    import lpr_pkg::*;

    localparam int FRAME_W      = 640;
    localparam int IDLE_PCT     = 22;
    localparam int ITEM_TARGET  = 850;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;

    logic i_clk;
    logic i_rst_n;

    lpr_req_if req_ch ();
    lpr_pix_if pix_ch ();

    line_pixel_rasterizer #(
        .FRAME_WIDTH(FRAME_W)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_pix   (pix_ch)
    );

    t_req req_fifo[$];
    t_pix pixel_expect_q[$];

    int   words_pushed;
    int   words_accepted;
    int   err_count;
    int   cycles;
    int   holds_asked;
    int   holds_served;
    int   hold_left;
    logic word_taken;
    logic calm;

    // no random idling on either side inside this window
    assign calm = (words_accepted >= 300) && (words_accepted < 450);

    // line tracer state
    logic        line_on;
    logic [9:0]  col_next;
    logic [9:0]  col_first;
    logic [9:0]  col_final;
    logic [8:0]  row_first;
    logic [8:0]  row_final;
    logic [23:0] line_rgb;

    function automatic bit trace_pixel(input t_req r, output t_pix p);
        logic [9:0] x;
        int span, run, y, idx;
        p = '0;
        if (r.req_type == REQ_START) begin
            col_first = r.x_start;
            row_first = r.y_start;
            col_final = r.x_end;
            row_final = r.y_end;
            line_rgb  = {r.red_in, r.green_in, r.blue_in};
            line_on   = 1'b0;
            if (col_final < col_first)
                return 1'b0;
            x = col_first;
        end else begin
            if (!line_on)
                return 1'b0;
            x = col_next;
        end
        span = int'(col_final) - int'(col_first);
        run  = int'(x) - int'(col_first);
        if (span == 0)
            y = int'(row_first);
        else if (row_final >= row_first)
            y = int'(row_first) + (int'(row_final) - int'(row_first)) * run / span;
        else
            y = int'(row_first) - (int'(row_first) - int'(row_final)) * run / span;
        idx = int'(x) + FRAME_W * y;
        p.pixel_x     = x;
        p.pixel_y     = y[8:0];
        p.pixel_index = idx[18:0];
        p.red_out     = line_rgb[23:16];
        p.green_out   = line_rgb[15:8];
        p.blue_out    = line_rgb[7:0];
        p.last_pixel  = (x == col_final);
        line_on  = !p.last_pixel;
        col_next = x + 10'd1;
        return 1'b1;
    endfunction

    task automatic check_field(input string tag, input int want, input int got);
        if (want != got) begin
            err_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, tag, want, got);
        end
    endtask

    task automatic push_start(input int xs, input int ys, input int xe, input int ye,
                              input int r, input int g, input int b);
        t_req w;
        w.req_type = REQ_START;
        w.x_start  = xs[9:0];
        w.y_start  = ys[8:0];
        w.x_end    = xe[9:0];
        w.y_end    = ye[8:0];
        w.red_in   = r[7:0];
        w.green_in = g[7:0];
        w.blue_in  = b[7:0];
        req_fifo.push_back(w);
        words_pushed++;
    endtask

    // start fields are ignored on next, so they carry noise
    task automatic push_next();
        t_req w;
        w = t_req'({$urandom, $urandom});
        w.req_type = REQ_NEXT;
        req_fifo.push_back(w);
        words_pushed++;
    endtask

    task automatic wait_drained();
        while (req_fifo.size() != 0 || req_ch.valid || pixel_expect_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic gen_random_lines();
        int sel, xs, span, nexts;
        t_req w;
        while (words_pushed < ITEM_TARGET) begin
            sel = $urandom_range(99);
            if (sel < 72) begin
                xs   = $urandom_range(1023);
                span = ($urandom_range(9) == 0) ? $urandom_range(80) : $urandom_range(10);
                if (xs + span > 1023)
                    span = 1023 - xs;
                push_start(xs, $urandom_range(511), xs + span, $urandom_range(511),
                           $urandom_range(255), $urandom_range(255), $urandom_range(255));
                nexts = span;
                sel = $urandom_range(9);
                if (sel == 0)
                    nexts = $urandom_range(span);          // abandoned, restart follows
                else if (sel == 1)
                    nexts = span + $urandom_range(1, 2);   // runs past the end
                repeat (nexts) push_next();
            end else if (sel < 82) begin
                xs = $urandom_range(1, 1023);
                push_start(xs, $urandom_range(511), $urandom_range(xs - 1),
                           $urandom_range(511), $urandom_range(255), $urandom_range(255),
                           $urandom_range(255));
                if ($urandom_range(1))
                    push_next();
            end else begin
                w = t_req'({$urandom, $urandom});
                req_fifo.push_back(w);
                words_pushed++;
            end
        end
    endtask

    // monitor and predictor
    always @(posedge i_clk) begin : sample
        t_pix want;
        t_pix got;
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                word_taken <= 1'b1;
                words_accepted++;
                if (trace_pixel(req_ch.payload, want))
                    pixel_expect_q.push_back(want);
            end
            if (pix_ch.valid && pix_ch.ready) begin
                got = pix_ch.payload;
                if (pixel_expect_q.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected pixel word, expected none, got %p",
                             $time, got);
                end else begin
                    want = pixel_expect_q.pop_front();
                    check_field("pixel_x", int'(want.pixel_x), int'(got.pixel_x));
                    check_field("pixel_y", int'(want.pixel_y), int'(got.pixel_y));
                    check_field("pixel_index", int'(want.pixel_index),
                                int'(got.pixel_index));
                    check_field("red_out", int'(want.red_out), int'(got.red_out));
                    check_field("green_out", int'(want.green_out), int'(got.green_out));
                    check_field("blue_out", int'(want.blue_out), int'(got.blue_out));
                    check_field("last_pixel", int'(want.last_pixel),
                                int'(got.last_pixel));
                end
            end
        end
    end

    // request driver: holds a word until taken, idles only between words
    always @(negedge i_clk) begin : send
        t_req w;
        if (!i_rst_n) begin
            req_ch.valid   <= 1'b0;
            req_ch.payload <= '0;
            word_taken     <= 1'b0;
        end else if (!req_ch.valid || word_taken) begin
            word_taken <= 1'b0;
            if (req_fifo.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                w = req_fifo.pop_front();
                req_ch.payload <= w;
                req_ch.valid   <= 1'b1;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // pixel receiver with random stalls and requested long holds
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pix_ch.ready <= 1'b0;
            hold_left    <= 0;
        end else if (hold_left > 0) begin
            pix_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (holds_served != holds_asked) begin
            holds_served <= holds_asked;
            hold_left    <= LONG_HOLD;
            pix_ch.ready <= 1'b0;
        end else begin
            pix_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[line_pixel_rasterizer] ERROR");
            $finish;
        end
    end

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        int hold_mark;
        i_rst_n        = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        pix_ch.ready   = 1'b0;
        word_taken     = 1'b0;
        words_pushed   = 0;
        words_accepted = 0;
        err_count      = 0;
        cycles         = 0;
        holds_asked    = 0;
        holds_served   = 0;
        hold_left      = 0;
        line_on        = 1'b0;
        col_next       = '0;
        col_first      = '0;
        col_final      = '0;
        row_first      = '0;
        row_final      = '0;
        line_rgb       = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners
        push_next();                                   // next with no line
        push_start(0, 0, 0, 0, 0, 0, 0);               // single column, all zero
        push_start(1023, 511, 1023, 511, 255, 255, 255);
        push_start(7, 9, 3, 100, 18, 52, 86);          // reversed
        push_next();
        push_start(0, 0, 3, 511, 255, 0, 128);         // steep rise
        repeat (3) push_next();
        push_next();                                   // past the last column
        push_start(10, 480, 14, 0, 1, 2, 4);           // falling, abandoned
        repeat (2) push_next();
        push_start(1020, 5, 1023, 300, 170, 85, 240);  // ends at top column
        repeat (3) push_next();
        push_start(500, 0, 501, 511, 15, 240, 60);
        push_next();

        // sender waits for every pixel before going random
        wait_drained();

        hold_mark = words_accepted + 80;
        gen_random_lines();
        while (words_accepted < hold_mark)
            @(negedge i_clk);
        holds_asked++;

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (err_count == 0)
            $display("[line_pixel_rasterizer] OK");
        else
            $display("[line_pixel_rasterizer] ERROR");
        $finish;
    end

endmodule
